/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared codes and control/status bundles for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   // Request kinds (any other code behaves as top)
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_TOP    = 2'd1;
   localparam logic [1:0] REQ_POP    = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic       capture;     // latch the incoming request item
      logic       do_insert;   // insert the latched entry in sorted order
      logic       do_pop;      // remove the head entry
      logic       set_status;  // latch the status code below
      logic [1:0] status;      // status code of the current request
      logic       load_rsp;    // load the result register from the store
   } spq_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] kind;        // latched request kind
      logic       empty;       // store holds no entry
      logic       full;        // store holds DEPTH entries
   } spq_stat_type;

endpackage

/* hw/rtl/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: accept an item, update the store, then report the head.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  spq_pkg::spq_stat_type stat,
   output spq_pkg::spq_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_REPORT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.set_status = 1'b1;
            cmd.status     = spq_pkg::ST_OK;
            case (stat.kind)
               spq_pkg::REQ_INSERT: begin
                  if (stat.full) begin
                     cmd.status = spq_pkg::ST_FULL;
                  end else begin
                     cmd.do_insert = 1'b1;
                  end
               end
               spq_pkg::REQ_POP: begin
                  if (stat.empty) begin
                     cmd.status = spq_pkg::ST_EMPTY;
                  end else begin
                     cmd.do_pop = 1'b1;
                  end
               end
               default: begin
                  if (stat.empty) begin
                     cmd.status = spq_pkg::ST_EMPTY;
                  end
               end
            endcase
            state_in = S_REPORT;
         end
         S_REPORT: begin
            // wait for the result register to drain
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // A result appears only after the report step
   a_rsp_from_report: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_REPORT)
      else $error("result raised outside report step");

   // Insert and pop are never issued together
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      !(cmd.do_insert && cmd.do_pop))
      else $error("insert and pop issued together");

   // A stalled result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff)
      else $error("stalled result dropped");

endmodule

/* hw/rtl/spq_datapath.sv */
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted slot register file with parallel compare, entry count and result
// register.
// ----------------------------------------------------------------------------
module spq_datapath #(
   parameter int DEPTH         = 16,
   parameter int PAYLOAD_BITS  = 32,
   parameter int PRIORITY_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::spq_cmd_type  cmd,
   output spq_pkg::spq_stat_type stat,
   input  logic [1:0]            req_kind,
   input  logic [31:0]           req_payload,
   input  logic [15:0]           req_priority,
   output logic                  rsp_head_valid,
   output logic [31:0]           rsp_head_payload,
   output logic [15:0]           rsp_head_priority,
   output logic [1:0]            rsp_status,
   output logic [4:0]            rsp_fill_count
);

   localparam int CW = $clog2(DEPTH + 1);

   // Latched request
   logic [1:0]                       kind_ff;
   logic [PAYLOAD_BITS-1:0]          new_pay_ff;
   logic signed [PRIORITY_BITS-1:0]  new_prio_ff;
   logic [1:0]                       status_ff;
   logic [63:0]                      pay_wide;
   logic [31:0]                      prio_wide;

   // Store
   logic [PAYLOAD_BITS-1:0]          slot_pay_ff  [DEPTH];
   logic signed [PRIORITY_BITS-1:0]  slot_prio_ff [DEPTH];
   logic [PAYLOAD_BITS-1:0]          slot_pay_in  [DEPTH];
   logic signed [PRIORITY_BITS-1:0]  slot_prio_in [DEPTH];
   logic [DEPTH-1:0]                 gt;
   logic [CW-1:0]                    count_ff;
   logic [CW-1:0]                    count_in;

   // Result register
   logic                             head_valid_ff;
   logic [31:0]                      head_pay_ff;
   logic [15:0]                      head_prio_ff;
   logic [1:0]                       rsp_status_ff;
   logic [4:0]                       fill_ff;
   logic [63:0]                      head_pay_wide;
   logic signed [31:0]               head_prio_wide;
   logic [31:0]                      fill_wide;

   assign pay_wide  = 64'(req_payload);
   assign prio_wide = 32'(req_priority);

   // Capture the request item and the status code
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff     <= req_kind;
         new_pay_ff  <= pay_wide[PAYLOAD_BITS-1:0];
         new_prio_ff <= prio_wide[PRIORITY_BITS-1:0];
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
   end

   // Compare every occupied slot with the new priority
   for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
      assign gt[i] = (CW'(i) < count_ff) && (slot_prio_ff[i] > new_prio_ff);
   end

   // Next slot contents: shift toward the head on pop, open a gap on insert
   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      always_comb begin
         slot_pay_in[i]  = slot_pay_ff[i];
         slot_prio_in[i] = slot_prio_ff[i];
         if (cmd.do_pop) begin
            if (i < DEPTH - 1) begin
               slot_pay_in[i]  = slot_pay_ff[(i + 1) % DEPTH];
               slot_prio_in[i] = slot_prio_ff[(i + 1) % DEPTH];
            end
         end else if (!gt[i]) begin
            if (i == 0) begin
               slot_pay_in[i]  = new_pay_ff;
               slot_prio_in[i] = new_prio_ff;
            end else if (gt[(i + DEPTH - 1) % DEPTH]) begin
               slot_pay_in[i]  = new_pay_ff;
               slot_prio_in[i] = new_prio_ff;
            end else begin
               slot_pay_in[i]  = slot_pay_ff[(i + DEPTH - 1) % DEPTH];
               slot_prio_in[i] = slot_prio_ff[(i + DEPTH - 1) % DEPTH];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_insert || cmd.do_pop) begin
         for (int i = 0; i < DEPTH; i++) begin
            slot_pay_ff[i]  <= slot_pay_in[i];
            slot_prio_ff[i] <= slot_prio_in[i];
         end
      end
   end

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.do_insert) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Head of the store, zero when empty
   assign head_pay_wide  = 64'(slot_pay_ff[0]);
   assign head_prio_wide = 32'(slot_prio_ff[0]);
   assign fill_wide      = 32'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         head_valid_ff <= (count_ff != '0);
         head_pay_ff   <= (count_ff != '0) ? head_pay_wide[31:0] : 32'd0;
         head_prio_ff  <= (count_ff != '0) ? head_prio_wide[15:0] : 16'd0;
         rsp_status_ff <= status_ff;
         fill_ff       <= fill_wide[4:0];
      end
   end

   assign stat.kind  = kind_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));

   assign rsp_head_valid    = head_valid_ff;
   assign rsp_head_payload  = head_pay_ff;
   assign rsp_head_priority = head_prio_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_fill_count    = fill_ff;

   // Count stays within the store
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   // Insert grows the count by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not add one entry");

   // Pop shrinks the count by one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.do_pop |=> count_ff == $past(count_ff) - CW'(1))
      else $error("pop did not remove one entry");

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue of up to DEPTH entries kept sorted by descending priority.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one request item per handshake; req_tuser carries the kind
//   (insert, top, pop), req_tdata the payload and signed priority of an
//   insert. A new entry goes after every entry of strictly greater priority.
//   rsp channel: exactly one result item per request, carrying the head entry
//   after the request, the entry count and a status (ok, empty, full).
//   An insert into a full store is dropped with status full; top or pop on
//   an empty store reports status empty and changes nothing.
// Sequence:
//   The request is latched at the accepting edge; the execute step then compares
//   all slots in parallel and shifts the sorted slot registers, and the report
//   step loads the result register and sets rsp_tvalid. One request at a
//   time: the next request is accepted only after the report step.
// Reset and stall:
//   Reset empties the store at once (the entry count clears; slot contents
//   are not cleared). While rsp_tready is low the result register holds; the
//   next request is still accepted and processed, then waits in its report
//   step until the held result is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
   parameter int DEPTH         = 16,
   parameter int PAYLOAD_BITS  = 32,
   parameter int PRIORITY_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] item_payload, [47:32] item_priority
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [31:0] head_payload, [47:32] head_priority,
                                    // [52:48] fill_count, [55:53] zero
   output logic [2:0]  rsp_tuser    // [0] head_valid, [2:1] status
);

   spq_pkg::spq_cmd_type  cmd;
   spq_pkg::spq_stat_type stat;
   logic                  head_valid;
   logic [31:0]           head_payload;
   logic [15:0]           head_priority;
   logic [1:0]            status;
   logic [4:0]            fill_count;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   spq_datapath #(
      .DEPTH         (DEPTH),
      .PAYLOAD_BITS  (PAYLOAD_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_tuser),
      .req_payload       (req_tdata[31:0]),
      .req_priority      (req_tdata[47:32]),
      .rsp_head_valid    (head_valid),
      .rsp_head_payload  (head_payload),
      .rsp_head_priority (head_priority),
      .rsp_status        (status),
      .rsp_fill_count    (fill_count)
   );

   // Pack the result item
   assign rsp_tdata = {3'b000, fill_count, head_priority, head_payload};
   assign rsp_tuser = {status, head_valid};

endmodule

/* test/tb_sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking testbench for the sorted priority queue.
// An initial block builds a list of requests: first a directed pass over empty
// hits, extreme priorities, ties, a full store and the unused request kind,
// then random epochs that lean toward filling, draining or a mix. A clocked
// driver presents them on the req channel with random idle bursts. A clocked
// monitor checks each result on the rsp channel against a behavioral sorted
// list that is updated on every accepted request. The rsp side stalls at
// random. Neither side idles during the last part of the run.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH   = 16;
   localparam int RANDOM_COUNT  = 980;
   localparam int CALM_TAIL     = 100;
   localparam int REPORT_LIMIT  = 10;
   localparam int DRAIN_CYCLES  = 8;

   localparam logic [1:0] REQ_SPARE = 2'd3;   // unused kind, acts as top

   typedef struct packed {
      logic [1:0]         kind;
      logic [31:0]        payload;
      logic signed [15:0] prio;
   } queue_request_type;

   typedef struct packed {
      logic               head_valid;
      logic [31:0]        head_payload;
      logic signed [15:0] head_priority;
      logic [1:0]         status;
      logic [4:0]         fill_count;
   } head_report_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // [31:0] item_payload, [47:32] item_priority
   logic [1:0]  req_tuser  = '0;   // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [55:0] rsp_tdata;         // [31:0] head_payload, [47:32] head_priority,
                                   // [52:48] fill_count, [55:53] zero
   logic [2:0]  rsp_tuser;         // [0] head_valid, [2:1] status

   // Behavioral copy of the sorted store
   logic [31:0]        slot_payload [QUEUE_DEPTH];
   logic signed [15:0] slot_priority[QUEUE_DEPTH];
   int                 entries_held = 0;

   queue_request_type pending_requests[$];
   head_report_type   expected_heads[$];

   // Driver and monitor working variables
   queue_request_type next_request;
   head_report_type   want;
   logic              next_valid;
   int                req_gap   = 0;
   int                rsp_stall = 0;

   int mismatches     = 0;
   int checked        = 0;
   int insert_count   = 0;
   int dropped_full   = 0;
   int pop_count      = 0;
   int empty_hits     = 0;
   int peak_fill      = 0;

   sorted_priority_queue uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Update the sorted list with one request and report the head afterwards
   function automatic head_report_type apply_request(input queue_request_type rq);
      head_report_type rep;
      int pos;
      int i;
      rep = '0;
      rep.status = spq_pkg::ST_OK;
      case (rq.kind)
         spq_pkg::REQ_INSERT: begin
            if (entries_held >= QUEUE_DEPTH) begin
               rep.status = spq_pkg::ST_FULL;
               dropped_full++;
            end else begin
               // new entry goes behind strictly greater priorities only
               pos = 0;
               while (pos < entries_held && slot_priority[pos] > rq.prio)
                  pos++;
               for (i = entries_held; i > pos; i--) begin
                  slot_payload[i]  = slot_payload[i-1];
                  slot_priority[i] = slot_priority[i-1];
               end
               slot_payload[pos]  = rq.payload;
               slot_priority[pos] = rq.prio;
               entries_held++;
            end
            insert_count++;
         end
         spq_pkg::REQ_POP: begin
            if (entries_held == 0) begin
               rep.status = spq_pkg::ST_EMPTY;
               empty_hits++;
            end else begin
               for (i = 0; i + 1 < entries_held; i++) begin
                  slot_payload[i]  = slot_payload[i+1];
                  slot_priority[i] = slot_priority[i+1];
               end
               entries_held--;
            end
            pop_count++;
         end
         default: begin
            if (entries_held == 0) begin
               rep.status = spq_pkg::ST_EMPTY;
               empty_hits++;
            end
         end
      endcase
      if (entries_held > 0) begin
         rep.head_valid    = 1'b1;
         rep.head_payload  = slot_payload[0];
         rep.head_priority = slot_priority[0];
      end
      rep.fill_count = 5'(entries_held);
      if (entries_held > peak_fill)
         peak_fill = entries_held;
      return rep;
   endfunction

   function automatic logic signed [15:0] pick_priority();
      logic [15:0] p;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: p = 16'($urandom_range(0, 6)) - 16'd3;   // dense ties
         5:             p = 16'h7fff;
         6:             p = 16'h8000;
         default:       p = 16'($urandom);
      endcase
      return p;
   endfunction

   task automatic add_request(input logic [1:0] kind, input logic [31:0] payload,
                              input logic signed [15:0] prio);
      queue_request_type rq;
      rq.kind     = kind;
      rq.payload  = payload;
      rq.prio     = prio;
      pending_requests.push_back(rq);
   endtask

   // Drive the req channel; predict each item as it is accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            next_request.kind     = req_tuser;
            next_request.payload  = req_tdata[31:0];
            next_request.prio     = req_tdata[47:32];
            expected_heads.push_back(apply_request(next_request));
         end
         if (!req_tvalid || req_tready) begin
            next_valid = 1'b0;
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_requests.size() > CALM_TAIL &&
                         $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(1, 3) - 1;
            end else if (pending_requests.size() > 0) begin
               next_request = pending_requests.pop_front();
               next_valid   = 1'b1;
               req_tdata <= {next_request.prio, next_request.payload};
               req_tuser <= next_request.kind;
            end
            req_tvalid <= next_valid;
         end
      end
   end

   // Stall the rsp channel in short bursts
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (pending_requests.size() > CALM_TAIL &&
                      $urandom_range(0, 5) == 0) begin
            rsp_stall = $urandom_range(1, 3) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Check each accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_heads.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: tdata=%h tuser=%h", rsp_tdata, rsp_tuser);
         end else begin
            want = expected_heads.pop_front();
            checked++;
            if (rsp_tuser[0]      !== want.head_valid    ||
                rsp_tdata[31:0]   !== want.head_payload  ||
                rsp_tdata[47:32]  !== want.head_priority ||
                rsp_tdata[52:48]  !== want.fill_count    ||
                rsp_tdata[55:53]  !== 3'd0               ||
                rsp_tuser[2:1]    !== want.status) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"mismatch on result %0d: valid %b/%b payload %h/%h ",
                            "priority %0d/%0d fill %0d/%0d status %0d/%0d pad %b"},
                           checked, want.head_valid, rsp_tuser[0],
                           want.head_payload, rsp_tdata[31:0],
                           want.head_priority, $signed(rsp_tdata[47:32]),
                           want.fill_count, rsp_tdata[52:48],
                           want.status, rsp_tuser[2:1], rsp_tdata[55:53]);
            end
         end
      end
   end

   // Build the stimulus, release reset, then wait for the last result
   initial begin
      int made;
      int epoch_left;
      int mode;
      int pick;
      logic [1:0] kind;

      // directed: empty hits, extremes, ties, filling past full, spare kind
      add_request(spq_pkg::REQ_TOP,    32'h0,        16'sd0);
      add_request(spq_pkg::REQ_POP,    32'hffffffff, -16'sd1);
      add_request(REQ_SPARE,           32'h0,        16'sd0);
      add_request(spq_pkg::REQ_INSERT, 32'hffffffff, 16'sh7fff);
      add_request(spq_pkg::REQ_INSERT, 32'h00000000, 16'sh8000);
      add_request(spq_pkg::REQ_INSERT, 32'ha5a5a5a5, 16'sh7fff);   // tie goes ahead
      add_request(spq_pkg::REQ_INSERT, 32'h5a5a5a5a, 16'sh8000);   // tie at the tail
      add_request(spq_pkg::REQ_INSERT, 32'h00000001, 16'sd0);
      add_request(spq_pkg::REQ_INSERT, 32'h80000000, -16'sd1);
      add_request(spq_pkg::REQ_INSERT, 32'h7fffffff, 16'sd1);
      for (int i = 0; i < 9; i++)
         add_request(spq_pkg::REQ_INSERT, $urandom, pick_priority());
      add_request(spq_pkg::REQ_INSERT, 32'hdeadbeef, 16'sh7fff);   // dropped, full
      add_request(spq_pkg::REQ_TOP,    32'h0,        16'sd0);
      add_request(REQ_SPARE,           32'hffffffff, 16'shffff);
      add_request(spq_pkg::REQ_POP,    32'h0,        16'sd0);

      // random epochs that lean toward filling, draining or a mix
      made = 0;
      epoch_left = 0;
      mode = 0;
      while (made < RANDOM_COUNT) begin
         if (epoch_left == 0) begin
            epoch_left = $urandom_range(10, 40);
            mode = $urandom_range(0, 2);
         end
         pick = $urandom_range(0, 99);
         if (pick < 5)
            kind = REQ_SPARE;
         else if (pick < 15)
            kind = spq_pkg::REQ_TOP;
         else if (mode == 0)
            kind = (pick < 85) ? spq_pkg::REQ_INSERT : spq_pkg::REQ_POP;
         else if (mode == 1)
            kind = (pick < 80) ? spq_pkg::REQ_POP : spq_pkg::REQ_INSERT;
         else
            kind = (pick < 57) ? spq_pkg::REQ_INSERT : spq_pkg::REQ_POP;
         add_request(kind, $urandom, pick_priority());
         epoch_left--;
         made++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_heads.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results: %0d inserts (%0d dropped on a full store), %0d pops,",
               checked, insert_count, dropped_full, pop_count);
      $display("%0d requests on an empty store, deepest fill %0d, %0d mismatches.",
               empty_hits, peak_fill, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
